// ----- rtl/sorted_priority_insert_queue_top_macros.svh -----
`ifndef SORTED_PRIORITY_INSERT_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_INSERT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    localparam int VALUE_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int RIDX_W    = 5;
    localparam int POS_OUT_W = 5;
    localparam int CNT_OUT_W = 6;
    localparam int KEY_W     = PRIO_W + VALUE_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] item_value;
        logic [PRIO_W-1:0]         item_priority;
        logic [RIDX_W-1:0]         read_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_OUT_W-1:0]      insert_position;
        logic signed [VALUE_W-1:0] out_value;
        logic [PRIO_W-1:0]         out_priority;
        logic [CNT_OUT_W-1:0]      entry_count;
    } rsp_t;

    // priority on top, value with sign flipped below: one unsigned compare
    function automatic logic [KEY_W-1:0] sort_key(entry_t e);
        sort_key = {e.prio, ~e.value[VALUE_W-1], e.value[VALUE_W-2:0]};
    endfunction

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*;
#(
    parameter int CNT_W    = 6,
    parameter int CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             shift_en,
    input  entry_t           new_entry,
    input  entry_t           prev_entry,
    input  logic             prev_lt,
    input  logic [CNT_W-1:0] count,
    output entry_t           entry,
    output logic             lt
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = IDX < count;
    assign lt       = occupied && (sort_key(entry_reg) < sort_key(new_entry));
    assign entry    = entry_reg;

    // smaller entries stay; the first cell not smaller takes the new item,
    // the rest take their lower neighbour
    always_comb
    begin
        entry_next = entry_reg;
        if (shift_en && !lt)
        begin
            entry_next = prev_lt ? new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/spq_pos_enc.sv -----
`timescale 1ns / 1ps

module spq_pos_enc import spq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int POS_W = $clog2(QUEUE_DEPTH_DEF)
)
(
    input  logic [DEPTH-1:0] onehot,
    output logic [POS_W-1:0] pos
);

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pos = pos | (onehot[i] ? POS_W'(i) : '0);
        end
    end

endmodule

// ----- rtl/sorted_priority_insert_queue_top.sv -----
`timescale 1ns / 1ps
// Channel | Signals                        | Carries
// req     | req_valid, req_ready, req      | command, value, priority, read index
// rsp     | rsp_valid, rsp_ready, rsp      | status, position, entry read, count
//
// One item per cycle while req_ready is high; its result is registered and shows in the cycle after acceptance.
// The cell row compares every entry with the new key in parallel and shifts on the accepting clock edge.
// req_ready is low only while a result waits and rsp_ready is low.
// Reset empties the queue at once (count to zero); entry contents stay undefined.

module sorted_priority_insert_queue_top import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

`include "sorted_priority_insert_queue_top_macros.svh"

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W     = $clog2(QUEUE_DEPTH);
    localparam int CMP_W     = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam int READ_SPAN = (QUEUE_DEPTH < (1 << RIDX_W)) ? QUEUE_DEPTH : (1 << RIDX_W);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    logic               full;
    logic               shift_en;
    logic               range_err;
    entry_t             new_entry;
    entry_t             rd_entry;
    entry_t             cell_q [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   lt_chain;
    logic [QUEUE_DEPTH-1:0] edge_oh;
    logic [POS_W-1:0]   pos;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign shift_en  = accept && (req.cmd == CMD_INSERT) && !full;
    assign new_entry = '{value: req.item_value, prio: req.item_priority};

    assign lt_chain[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            spq_cell #(
                .CNT_W    (CNT_W),
                .CELL_IDX (g)
            ) u_cell (
                .clk        (clk),
                .shift_en   (shift_en),
                .new_entry  (new_entry),
                .prev_entry ((g == 0) ? new_entry : cell_q[(g == 0) ? 0 : g - 1]),
                .prev_lt    (lt_chain[g]),
                .count      (count_reg),
                .entry      (cell_q[g]),
                .lt         (lt_chain[g+1])
            );
            // smaller-than flags form a thermometer; its edge is the landing slot
            assign edge_oh[g] = lt_chain[g] && !lt_chain[g+1];
        end
    endgenerate

    spq_pos_enc #(
        .DEPTH (QUEUE_DEPTH),
        .POS_W (POS_W)
    ) u_pos_enc (
        .onehot (edge_oh),
        .pos    (pos)
    );

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < READ_SPAN; i++)
        begin
            if (req.read_index == RIDX_W'(i))
            begin
                rd_entry = cell_q[i];
            end
        end
    end

    assign range_err = CMP_W'(req.read_index) >= CMP_W'(count_reg);

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;
        case (req.cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    rsp_next.insert_position = POS_OUT_W'(pos);
                    count_next               = count_reg + CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (range_err)
                begin
                    rsp_next.status = STAT_RANGE;
                end
                else
                begin
                    rsp_next.out_value    = rd_entry.value;
                    rsp_next.out_priority = rd_entry.prio;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.entry_count = CNT_OUT_W'(count_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
    `SPQ_ASSERT_NEXT(a_clear_empties, accept && req.cmd == CMD_CLEAR, count_reg == '0, "clear left entries")
    `SPQ_ASSERT_NEXT(a_full_drop, accept && req.cmd == CMD_INSERT && full, $stable(count_reg), "dropped insert changed count")
    `SPQ_ASSERT_NEXT(a_result_follows, accept, rsp_valid, "accepted item gave no result")

endmodule

// ----- tb/sv/spq_order_checker.sv -----
`timescale 1ns / 1ps

module spq_order_checker import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   drops_seen
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    logic signed [VALUE_W-1:0] shadow_value [DEPTH];
    logic [PRIO_W-1:0]         shadow_prio  [DEPTH];
    int                        shadow_count;

    rsp_t awaited_rsp_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] queue check: %s got %0d, wanted %0d", $time, what, got, want);
        fail_count++;
    endtask

    // strict order: priority first, signed value as tie-break
    function automatic bit key_below(input logic [PRIO_W-1:0] pa,
                                     input logic signed [VALUE_W-1:0] va,
                                     input logic [PRIO_W-1:0] pb,
                                     input logic signed [VALUE_W-1:0] vb);
        return (pa < pb) || (pa == pb && va < vb);
    endfunction

    function automatic rsp_t apply_command(input req_t r);
        rsp_t o;
        int   slot;
        o = '0;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    o.status = STAT_FULL;
                end
                else
                begin
                    // lands after every strictly smaller entry
                    slot = 0;
                    while (slot < shadow_count &&
                           key_below(shadow_prio[slot], shadow_value[slot],
                                     r.item_priority, r.item_value))
                        slot++;
                    for (int i = shadow_count; i > slot; i--)
                    begin
                        shadow_value[i] = shadow_value[i-1];
                        shadow_prio[i]  = shadow_prio[i-1];
                    end
                    shadow_value[slot] = r.item_value;
                    shadow_prio[slot]  = r.item_priority;
                    shadow_count++;
                    o.insert_position = POS_OUT_W'(slot);
                end
            end
            CMD_READ:
            begin
                if (int'(r.read_index) >= shadow_count)
                begin
                    o.status = STAT_RANGE;
                end
                else
                begin
                    o.out_value    = shadow_value[r.read_index];
                    o.out_priority = shadow_prio[r.read_index];
                end
            end
            CMD_CLEAR:
            begin
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        o.entry_count = CNT_OUT_W'(shadow_count);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            awaited_rsp_q.delete();
            shadow_count = 0;
            pending      = 0;
            fail_count   = 0;
            results_seen = 0;
            drops_seen   = 0;
        end
        else
        begin
            // a result accepted now belongs to an earlier item, so retire first
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    report_mismatch("result with nothing awaited, count", rsp.entry_count, -1);
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    results_seen++;
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.insert_position !== want.insert_position)
                        report_mismatch("insert_position", rsp.insert_position,
                                        want.insert_position);
                    if (rsp.out_value !== want.out_value)
                        report_mismatch("out_value", rsp.out_value, want.out_value);
                    if (rsp.out_priority !== want.out_priority)
                        report_mismatch("out_priority", rsp.out_priority, want.out_priority);
                    if (rsp.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp.entry_count, want.entry_count);
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_command(req);
                if (req.cmd == CMD_INSERT && want.status == STAT_FULL)
                    drops_seen++;
                awaited_rsp_q.push_back(want);
            end
            pending = awaited_rsp_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_sorted_priority_insert_queue_top.sv -----
`timescale 1ns / 1ps

module tb_sorted_priority_insert_queue_top;
    import spq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int PHASE_ITEMS    = 630;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 3000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    int fail_count;
    int pending;
    int results_seen;
    int drops_seen;

    int tx_idle_pct = 29;
    int rx_idle_pct = 69;
    bit rx_hold_go  = 1'b0;
    int fill_level  = 0;
    int n_sent      = 0;
    int n_by_cmd [4];
    int stall_cycles = 0;

    sorted_priority_insert_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    spq_order_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .drops_seen   (drops_seen)
    );

    always #5 clk = ~clk;

    // receiver: random back-pressure, plus long hold-offs on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_go)
            begin
                rx_hold_go = 1'b0;
                rsp_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VALUE_W-1:0] value,
                                      input logic [PRIO_W-1:0] prio,
                                      input logic [RIDX_W-1:0] idx);
        req_t r;
        r.cmd           = cmd;
        r.item_value    = value;
        r.item_priority = prio;
        r.read_index    = idx;
        return r;
    endfunction

    task automatic send_cmd(input req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        n_sent++;
        n_by_cmd[r.cmd]++;
        if (r.cmd == CMD_INSERT && fill_level < DEPTH)
            fill_level++;
        else if (r.cmd == CMD_CLEAR)
            fill_level = 0;
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // narrow keys force ties and near-ties; wide keys exercise every bit
    function automatic req_t rand_insert();
        logic signed [VALUE_W-1:0] v;
        logic [PRIO_W-1:0]         p;
        if ($urandom_range(1))
        begin
            v = VALUE_W'($signed($urandom_range(0, 7)) - 4);
            p = PRIO_W'($urandom_range(0, 3));
            if ($urandom_range(3) == 0)
                p = '1;
        end
        else
        begin
            v = VALUE_W'($urandom);
            p = PRIO_W'($urandom);
        end
        return make_req(CMD_INSERT, v, p, RIDX_W'($urandom));
    endfunction

    function automatic req_t rand_read();
        logic [RIDX_W-1:0] idx;
        if (fill_level > 0 && $urandom_range(99) < 75)
            idx = RIDX_W'($urandom_range(0, fill_level - 1));
        else
            idx = RIDX_W'($urandom);
        return make_req(CMD_READ, VALUE_W'($urandom), PRIO_W'($urandom), idx);
    endfunction

    task automatic run_phase(input int n_items);
        int start;
        int pick;
        int c;
        start = n_sent;
        while (n_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                // fill past capacity, then read back
                send_cmd(make_req(CMD_CLEAR, VALUE_W'($urandom), PRIO_W'($urandom),
                                  RIDX_W'($urandom)));
                repeat (DEPTH + $urandom_range(1, 4)) send_cmd(rand_insert());
                repeat ($urandom_range(4, 12)) send_cmd(rand_read());
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(10, 40))
                begin
                    c = $urandom_range(99);
                    if (c < 48)
                        send_cmd(rand_insert());
                    else if (c < 90)
                        send_cmd(rand_read());
                    else if (c < 95)
                        send_cmd(make_req(CMD_CLEAR, VALUE_W'($urandom), PRIO_W'($urandom),
                                          RIDX_W'($urandom)));
                    else
                        send_cmd(make_req(CMD_NOP, VALUE_W'($urandom), PRIO_W'($urandom),
                                          RIDX_W'($urandom)));
                end
            end
            else
            begin
                repeat ($urandom_range(3, 10))
                begin
                    if ($urandom_range(1))
                        send_cmd(make_req(CMD_NOP, VALUE_W'($urandom), PRIO_W'($urandom),
                                          RIDX_W'($urandom)));
                    else
                        send_cmd(make_req(CMD_READ, VALUE_W'($urandom), PRIO_W'($urandom),
                                          RIDX_W'($urandom)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty read, unused command, key extremes, ties, overruns
        send_cmd(make_req(CMD_READ, '0, '0, '0));
        send_cmd(make_req(CMD_NOP, '1, '1, '1));
        send_cmd(make_req(CMD_INSERT, -16'sd32768, 8'd255, '0));
        send_cmd(make_req(CMD_INSERT, 16'sd32767, 8'd0, '0));
        send_cmd(make_req(CMD_INSERT, 16'sd0, 8'd128, '0));
        send_cmd(make_req(CMD_INSERT, 16'sd0, 8'd128, '1));
        send_cmd(make_req(CMD_INSERT, -16'sd1, 8'd128, '0));
        send_cmd(make_req(CMD_INSERT, 16'sd32767, 8'd255, '0));
        send_cmd(make_req(CMD_INSERT, -16'sd32768, 8'd0, '0));
        for (int i = 0; i < 8; i++)
            send_cmd(make_req(CMD_READ, '1, '1, RIDX_W'(i)));
        send_cmd(make_req(CMD_READ, '0, '0, '1));
        send_cmd(make_req(CMD_CLEAR, '1, '1, '1));
        send_cmd(make_req(CMD_READ, '0, '0, '0));
        send_cmd(make_req(CMD_INSERT, 16'sd5, 8'd5, '0));
        drain();

        run_phase(PHASE_ITEMS);
        drain();

        tx_idle_pct = 69;
        rx_idle_pct = 29;
        rx_hold_go  = 1'b1;
        run_phase(PHASE_ITEMS);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_go  = 1'b1;
        run_phase(PHASE_ITEMS);
        drain();
        repeat (4) @(posedge clk);

        $display("Covered %0d commands: %0d inserts (%0d dropped on a full queue), %0d reads,",
                 n_sent, n_by_cmd[CMD_INSERT], drops_seen, n_by_cmd[CMD_READ]);
        $display("%0d clears, %0d unused-code commands; %0d results compared, %0d failures",
                 n_by_cmd[CMD_CLEAR], n_by_cmd[CMD_NOP], results_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
